>>> rtl/stack_machine_alu_macros.svh
// Assertion helpers shared by the stack machine RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef STACK_MACHINE_ALU_MACROS_SVH
`define STACK_MACHINE_ALU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sma_pkg.sv
`default_nettype none

package sma_pkg;

  localparam int WORD_W      = 32;
  localparam int DEPTH_OUT_W = 9;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_OP   = 1'b1;

  typedef enum logic [3:0] {
    OP_EQ, OP_NE, OP_GE, OP_LE, OP_GT, OP_LT, OP_OR, OP_XOR,
    OP_AND, OP_NOT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NEG
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_UNDER, ST_OVER, ST_DIVZ
  } status_t;

  typedef struct packed {
    logic              start;
    logic              is_mod;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] result;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/sma_divider.sv
`default_nettype none

module sma_divider import sma_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(WORD_W);

  typedef enum logic [1:0] {
    D_IDLE, D_RUN, D_FIX
  } dstate_t;

  dstate_t           state;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] den;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] rem;
  logic              num_neg;
  logic              den_neg;
  logic              is_mod;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;
  logic              take;
  logic [WORD_W-1:0] num_mag;
  logic [WORD_W-1:0] den_mag;

  always_comb begin
    num_mag = req.dividend[WORD_W-1] ? -req.dividend : req.dividend;
    den_mag = req.divisor[WORD_W-1] ? -req.divisor : req.divisor;
    rem_sh  = {rem, quo[WORD_W-1]};
    diff    = rem_sh - {1'b0, den};
    take    = !diff[WORD_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (req.start) begin
            num_neg <= req.dividend[WORD_W-1];
            den_neg <= req.divisor[WORD_W-1];
            is_mod  <= req.is_mod;
            den     <= den_mag;
            quo     <= num_mag;
            rem     <= '0;
            cnt     <= CNT_W'(WORD_W - 1);
            state   <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= take ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
          quo <= {quo[WORD_W-2:0], take};
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          if (is_mod) begin
            rsp.result <= num_neg ? -rem : rem;
          end else begin
            rsp.result <= (num_neg ^ den_neg) ? -quo : quo;
          end
          rsp.done <= 1'b1;
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/stack_machine_alu.sv
// Evaluation stack of signed 32-bit words with an operation unit.
// Input channel (in_valid / in_stall) carries one request: a push of push_value
// when req_type is 0, or the operation named by opcode when req_type is 1.
// Output channel (out_valid / out_stall) returns one result per request: the
// top word (zero when empty), the depth and a status code.
// The stack lives in a single-port synchronous RAM with a top-of-stack register.
// A push or a unary operation updates the stack on acceptance and then presents its result.
// Comparisons, logic, add, subtract and multiply go through RAM read of the
// second word, operate, write back and present, in that order.
// Divide and modulo wait on the bit-serial divider, which retires one quotient
// bit per cycle.
// One request is in flight at a time; the next one is taken as soon as the
// previous result has been registered, even while the receiver stalls it.
// A stalled result holds its value until it is taken.
// Reset empties the stack at once; the RAM contents are not cleared.
`default_nettype none

`include "stack_machine_alu_macros.svh"

module stack_machine_alu import sma_pkg::*; #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic [3:0]               opcode,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] top_value,
  output logic [DEPTH_OUT_W-1:0]   stack_depth,
  output logic [1:0]               status
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_DIV, S_WRITE, S_DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  sp;
  logic [WORD_W-1:0] top;
  logic [WORD_W-1:0] res;
  op_t               op_q;
  status_t           st;

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  logic              in_acc;
  logic              out_free;
  op_t               op_in;
  logic              unary_in;
  logic              div_in;
  logic              full;
  logic [CNT_W-1:0]  sp_m1;
  logic [CNT_W-1:0]  sp_m2;
  logic [WORD_W-1:0] unary_val;
  logic [WORD_W-1:0] alu_res;
  logic              div_q;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    op_in     = op_t'(opcode);
    unary_in  = (op_in == OP_NOT) || (op_in == OP_NEG);
    div_in    = (op_in == OP_DIV) || (op_in == OP_MOD);
    div_q     = (op_q == OP_DIV) || (op_q == OP_MOD);
    full      = (sp == CNT_W'(STACK_DEPTH));
    sp_m1     = sp - CNT_W'(1);
    sp_m2     = sp - CNT_W'(2);
    unary_val = (op_in == OP_NOT) ? ~top : -top;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = sp_m2[ADDR_W-1:0];
    mem_wdata = res;
    if (state == S_WRITE) begin
      mem_we = 1'b1;
    end else if (in_acc) begin
      if (req_type == REQ_PUSH) begin
        mem_we    = !full;
        mem_addr  = sp[ADDR_W-1:0];
        mem_wdata = push_value;
      end else if (unary_in) begin
        mem_we    = (sp != '0);
        mem_addr  = sp_m1[ADDR_W-1:0];
        mem_wdata = unary_val;
      end else begin
        mem_re = (sp >= CNT_W'(2)) && !(div_in && top == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_comb begin
    unique case (op_q)
      OP_EQ:   alu_res = WORD_W'($signed(rdata) == $signed(top));
      OP_NE:   alu_res = WORD_W'($signed(rdata) != $signed(top));
      OP_GE:   alu_res = WORD_W'($signed(rdata) >= $signed(top));
      OP_LE:   alu_res = WORD_W'($signed(rdata) <= $signed(top));
      OP_GT:   alu_res = WORD_W'($signed(rdata) > $signed(top));
      OP_LT:   alu_res = WORD_W'($signed(rdata) < $signed(top));
      OP_OR:   alu_res = rdata | top;
      OP_XOR:  alu_res = rdata ^ top;
      OP_AND:  alu_res = rdata & top;
      OP_ADD:  alu_res = rdata + top;
      OP_SUB:  alu_res = rdata - top;
      OP_MUL:  alu_res = rdata * top;
      OP_NOT, OP_DIV, OP_MOD, OP_NEG: alu_res = '0;
    endcase
  end

  always_comb begin
    div_req.start    = (state == S_EXEC) && div_q;
    div_req.is_mod   = (op_q == OP_MOD);
    div_req.dividend = rdata;
    div_req.divisor  = top;
  end

  sma_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      op_q      <= OP_EQ;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            st    <= ST_OK;
            op_q  <= op_in;
            state <= S_DONE;
            if (req_type == REQ_PUSH) begin
              if (full) begin
                st <= ST_OVER;
              end else begin
                top <= push_value;
                sp  <= sp + CNT_W'(1);
              end
            end else if (unary_in) begin
              if (sp == '0) begin
                st <= ST_UNDER;
              end else begin
                top <= unary_val;
              end
            end else if (sp < CNT_W'(2)) begin
              st <= ST_UNDER;
            end else if (div_in && top == '0) begin
              st <= ST_DIVZ;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (div_q) begin
            state <= S_DIV;
          end else begin
            res   <= alu_res;
            state <= S_WRITE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            res   <= div_rsp.result;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          top   <= res;
          sp    <= sp_m1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            top_value   <= (sp != '0) ? top : '0;
            stack_depth <= DEPTH_OUT_W'(sp);
            status      <= st;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SMA_ASSERT_NOW(a_sp_bound, 1'b1, sp <= CNT_W'(STACK_DEPTH), "Stack pointer past depth.")
  `SMA_ASSERT_NEXT(a_push_grows, in_acc && req_type == REQ_PUSH && !full,
                   sp == $past(sp) + CNT_W'(1), "Push did not grow the stack.")
  `SMA_ASSERT_NEXT(a_pop_shrinks, state == S_WRITE,
                   sp == $past(sp) - CNT_W'(1), "Binary operation did not pop.")
  `SMA_ASSERT_NOW(a_div_done, div_rsp.done, state == S_DIV,
                  "Divider finished outside its wait state.")

endmodule

`default_nettype wire

>>> dv/tb_stack_machine_alu.sv
`timescale 1ns / 100ps

module tb_stack_machine_alu;
  import sma_pkg::*;

  localparam int STACK_WORDS = 256;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 50;

  typedef struct packed {
    logic [WORD_W-1:0]      top;
    logic [DEPTH_OUT_W-1:0] depth;
    status_t                st;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     req_type = REQ_PUSH;
  logic [3:0]               opcode = OP_EQ;
  logic signed [WORD_W-1:0] push_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [WORD_W-1:0] top_value;
  logic [DEPTH_OUT_W-1:0]   stack_depth;
  logic [1:0]               status;

  logic [WORD_W-1:0] stack_words [STACK_WORDS];
  int unsigned       depth_now = 0;
  stack_result_t     pending_results [$];
  stack_result_t     oldest;
  int                errors = 0;
  int                cycle_count = 0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;

  stack_machine_alu #(.STACK_DEPTH(STACK_WORDS)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .opcode     (opcode),
    .push_value (push_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .top_value  (top_value),
    .stack_depth(stack_depth),
    .status     (status)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic void apply_request(input logic rtype, input op_t op,
                                        input logic [WORD_W-1:0] val);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] r;
    longint            sa;
    longint            sb;
    status_t           st;
    stack_result_t     res;
    st = ST_OK;
    r = '0;
    if (rtype == REQ_PUSH) begin
      if (depth_now >= STACK_WORDS) begin
        st = ST_OVER;
      end else begin
        stack_words[depth_now] = val;
        depth_now++;
      end
    end else if (op == OP_NOT || op == OP_NEG) begin
      if (depth_now < 1) begin
        st = ST_UNDER;
      end else begin
        a = stack_words[depth_now - 1];
        stack_words[depth_now - 1] = (op == OP_NOT) ? ~a : (32'd0 - a);
      end
    end else if (depth_now < 2) begin
      st = ST_UNDER;
    end else begin
      a = stack_words[depth_now - 2];
      b = stack_words[depth_now - 1];
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      case (op)
        OP_EQ:  r = {31'd0, sa == sb};
        OP_NE:  r = {31'd0, sa != sb};
        OP_GE:  r = {31'd0, sa >= sb};
        OP_LE:  r = {31'd0, sa <= sb};
        OP_GT:  r = {31'd0, sa > sb};
        OP_LT:  r = {31'd0, sa < sb};
        OP_OR:  r = a | b;
        OP_XOR: r = a ^ b;
        OP_AND: r = a & b;
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_MUL: r = a * b;
        OP_DIV: begin
          if (sb == 0) st = ST_DIVZ;
          else r = 32'(sa / sb);
        end
        OP_MOD: begin
          if (sb == 0) st = ST_DIVZ;
          else r = 32'(sa % sb);
        end
        default: r = '0;
      endcase
      if (st != ST_DIVZ) begin
        stack_words[depth_now - 2] = r;
        depth_now--;
      end
    end
    res.top = (depth_now > 0) ? stack_words[depth_now - 1] : '0;
    res.depth = depth_now[DEPTH_OUT_W-1:0];
    res.st = st;
    pending_results.push_back(res);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: top=%0d depth=%0d status=%0d",
                 $time, top_value, stack_depth, status);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (top_value !== oldest.top) begin
          $display("%0t: top_value expected %0d actual %0d",
                   $time, $signed(oldest.top), top_value);
          errors++;
        end
        if (stack_depth !== oldest.depth) begin
          $display("%0t: stack_depth expected %0d actual %0d",
                   $time, oldest.depth, stack_depth);
          errors++;
        end
        if (status !== oldest.st) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.st, status);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input logic rtype, input op_t op,
                              input logic [WORD_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      req_type <= 1'($urandom);
      opcode <= 4'($urandom);
      push_value <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rtype;
    opcode <= op;
    push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(rtype, op, val);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 8)) - 32'd4;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t random_binary_op();
    op_t op;
    do op = op_t'($urandom_range(0, 15));
    while (op inside {OP_NOT, OP_NEG, OP_DIV, OP_MOD});
    return op;
  endfunction

  task automatic check_underflow();
    send_request(REQ_OP, OP_NOT, $urandom);
    send_request(REQ_OP, OP_ADD, $urandom);
    send_request(REQ_PUSH, OP_EQ, 32'h8000_0000);
    send_request(REQ_OP, OP_LT, $urandom);
    send_request(REQ_OP, OP_NEG, $urandom);
    send_request(REQ_OP, OP_NOT, $urandom);
  endtask

  task automatic check_operations();
    logic [WORD_W-1:0] operands [6];
    op_t               op;
    operands = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h1, 32'h1234_5678};
    for (int i = 0; i < 16; i++) begin
      op = op_t'(i);
      if (op != OP_NOT && op != OP_NEG) send_request(REQ_PUSH, OP_EQ, operands[i % 6]);
      send_request(REQ_OP, op, $urandom);
    end
  endtask

  task automatic check_division();
    send_request(REQ_PUSH, OP_MOD, 32'd100);
    send_request(REQ_PUSH, OP_MOD, 32'd0);
    send_request(REQ_OP, OP_DIV, $urandom);
    send_request(REQ_OP, OP_MOD, $urandom);
    send_request(REQ_PUSH, OP_EQ, 32'h8000_0000);
    send_request(REQ_PUSH, OP_EQ, 32'hffff_ffff);
    send_request(REQ_OP, OP_DIV, $urandom);
    send_request(REQ_PUSH, OP_EQ, 32'hffff_ffff);
    send_request(REQ_OP, OP_MOD, $urandom);
    send_request(REQ_PUSH, OP_EQ, -32'sd7);
    send_request(REQ_PUSH, OP_EQ, 32'd2);
    send_request(REQ_OP, OP_MOD, $urandom);
    send_request(REQ_PUSH, OP_EQ, 32'd7);
    send_request(REQ_PUSH, OP_EQ, -32'sd2);
    send_request(REQ_OP, OP_DIV, $urandom);
    drain_results();
  endtask

  task automatic check_overflow();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (depth_now < STACK_WORDS) send_request(REQ_PUSH, op_t'($urandom_range(0, 15)),
                                                 random_word());
    send_request(REQ_PUSH, OP_EQ, $urandom);
    send_request(REQ_PUSH, OP_NEG, $urandom);
    send_request(REQ_OP, OP_NOT, $urandom);
    send_request(REQ_OP, OP_ADD, $urandom);
    send_request(REQ_PUSH, OP_EQ, $urandom);
    send_request(REQ_PUSH, OP_EQ, $urandom);
    while (depth_now > 1) send_request(REQ_OP, random_binary_op(), $urandom);
    drain_results();
  endtask

  task automatic run_random_traffic(input int count, input int send_pct, input int stall_pct);
    logic rtype;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_results();
      rtype = ($urandom_range(0, 99) < ((depth_now < 3) ? 80 : 45)) ? REQ_PUSH : REQ_OP;
      send_request(rtype, op_t'($urandom_range(0, 15)), random_word());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    check_underflow();
    check_operations();
    check_division();
    check_overflow();
    run_random_traffic(260, 0, 0);
    run_random_traffic(260, 74, 0);
    run_random_traffic(260, 0, 74);
    run_random_traffic(260, 11, 11);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> stack_machine_alu.f
+incdir+rtl
rtl/sma_pkg.sv
rtl/sma_divider.sv
rtl/stack_machine_alu.sv
dv/tb_stack_machine_alu.sv
